[hw/rtl/packed_bit_field_array_unit_assert.svh]
// Assertion macros for the packed bit-field array unit.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PACKED_BIT_FIELD_ARRAY_UNIT_ASSERT_SVH
`define PACKED_BIT_FIELD_ARRAY_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define PBFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PBFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pbfa_pkg.sv]
// Shared types, constants and helper functions of the packed bit-field array unit.
// No dependencies.
package pbfa_pkg;

    localparam int STORE_BYTES_DEF = 4096;

    localparam int OPC_W   = 1;
    localparam int IDX_W   = 15;
    localparam int VAL_W   = 64;
    localparam int ST_W    = 2;
    localparam int WID_W   = 7;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int FIRST_W = IDX_W + WID_W;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 64;

    localparam logic [WID_W-1:0] WIDTH_RST = 7'd8;
    localparam logic [CNT_W-1:0] COUNT_RST = 16'd4096;

    localparam logic [OPC_W-1:0] OP_READ  = 1'b0;
    localparam logic [OPC_W-1:0] OP_WRITE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
    localparam logic [ST_W-1:0] ST_VALUE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_LOOKUP,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic calc;
        logic check;
        logic commit;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

    // Clamp the width register to 1..64.
    function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] cfg);
        logic [WID_W-1:0] w;
        if (cfg == '0) begin
            w = 7'd1;
        end else if (cfg > 7'd64) begin
            w = 7'd64;
        end else begin
            w = cfg;
        end
        return w;
    endfunction

    // Ones in the low w bits, w in 1..64.
    function automatic logic [VAL_W-1:0] width_mask(input logic [WID_W-1:0] w);
        logic [VAL_W-1:0] m;
        if (w >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << w[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

[hw/rtl/pbfa_ctrl.sv]
// Controller state machine of the packed bit-field array unit.
// Depends on pbfa_pkg and packed_bit_field_array_unit_assert.svh.
`include "packed_bit_field_array_unit_assert.svh"

module pbfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pbfa_pkg::t_sts    i_sts,
    output pbfa_pkg::t_cmd    o_cmd
);

    pbfa_pkg::t_state r_state;
    pbfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbfa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            pbfa_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = pbfa_pkg::S_IDLE;
                end
            end
            pbfa_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = pbfa_pkg::S_ADDR;
                end
            end
            pbfa_pkg::S_ADDR: begin
                o_cmd.calc = 1'b1;
                n_state    = pbfa_pkg::S_LOOKUP;
            end
            pbfa_pkg::S_LOOKUP: begin
                o_cmd.check = 1'b1;
                n_state     = pbfa_pkg::S_COMMIT;
            end
            pbfa_pkg::S_COMMIT: begin
                // hold until the output register can take the result
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = pbfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbfa_pkg::S_IDLE;
            end
        endcase
    end

    `PBFA_ASSERT_NEXT(a_accept_to_addr, o_in_ready && i_in_valid, r_state == pbfa_pkg::S_ADDR, "accepted item did not advance to address stage")
    `PBFA_ASSERT_NEXT(a_lookup_to_commit, r_state == pbfa_pkg::S_LOOKUP, r_state == pbfa_pkg::S_COMMIT, "lookup not followed by commit")
    `PBFA_ASSERT_NOW(a_commit_free, o_cmd.commit, i_sts.out_free, "commit while output register full")

endmodule

[hw/rtl/pbfa_dp.sv]
// Datapath of the packed bit-field array unit: configuration, address
// arithmetic, two banked word memories, read-modify-write and output register.
// Depends on pbfa_pkg and packed_bit_field_array_unit_assert.svh.
`include "packed_bit_field_array_unit_assert.svh"

module pbfa_dp #(
    parameter int STORE_BYTES = pbfa_pkg::STORE_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pbfa_pkg::t_cmd                    i_cmd,
    output pbfa_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_we,
    input  logic [pbfa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [pbfa_pkg::OPC_W-1:0]        i_opcode,
    input  logic [pbfa_pkg::IDX_W-1:0]        i_element_index,
    input  logic [pbfa_pkg::VAL_W-1:0]        i_write_value,
    output logic                              o_m_valid,
    input  logic                              i_m_ready,
    output logic [pbfa_pkg::VAL_W-1:0]        o_read_value,
    output logic [pbfa_pkg::ST_W-1:0]         o_status
);

    localparam int NUM_WORDS = (STORE_BYTES + 7) / 8;
    localparam int BANK_D    = (NUM_WORDS + 1) / 2;
    localparam int ROW_W     = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int CAP_BITS  = STORE_BYTES * 8;
    localparam int CAP_W     = $clog2(CAP_BITS + 1);
    localparam int CMP_W     = (CAP_W > pbfa_pkg::FIRST_W + 1) ? CAP_W : pbfa_pkg::FIRST_W + 1;
    localparam int WADR_W    = pbfa_pkg::FIRST_W - 6;
    localparam int VW        = pbfa_pkg::VAL_W;

    // configuration
    logic [pbfa_pkg::WID_W-1:0] r_width_cfg;
    logic [pbfa_pkg::CNT_W-1:0] r_count_cfg;
    logic [pbfa_pkg::WID_W-1:0] w_eff;

    // item registers
    logic [pbfa_pkg::OPC_W-1:0]   r_op;
    logic [pbfa_pkg::IDX_W-1:0]   r_idx;
    logic [VW-1:0]                r_val;
    logic [pbfa_pkg::FIRST_W-1:0] r_first;
    logic [pbfa_pkg::WID_W-1:0]   r_wid;
    logic [VW-1:0]                r_mask;
    logic                         r_cnt_ok;
    logic [pbfa_pkg::ST_W-1:0]    r_st;

    // clearing pass
    logic [ROW_W-1:0] r_clr_row;

    // memories
    logic [VW-1:0] mem_e [BANK_D];
    logic [VW-1:0] mem_o [BANK_D];
    logic [VW-1:0] r_q_e;
    logic [VW-1:0] r_q_o;

    // output register
    logic                      r_m_valid;
    logic [VW-1:0]             r_m_value;
    logic [pbfa_pkg::ST_W-1:0] r_m_status;

    logic [WADR_W-1:0]          word_k;
    logic [WADR_W:0]            word_kz;
    logic [WADR_W:0]            word_k1;
    logic [ROW_W-1:0]           row_e;
    logic [ROW_W-1:0]           row_o;
    logic                       odd_lo;
    logic [5:0]                 bit_off;
    logic [pbfa_pkg::FIRST_W:0] end_bit;
    logic                       cap_bad;
    logic [pbfa_pkg::ST_W-1:0]  n_st;
    logic [VW-1:0]              lo_word;
    logic [VW-1:0]              hi_word;
    logic [2*VW-1:0]            span;
    logic [2*VW-1:0]            span_shift;
    logic [2*VW-1:0]            wmask;
    logic [2*VW-1:0]            wdata;
    logic [2*VW-1:0]            span_new;
    logic [VW-1:0]              rd_value;
    logic                       do_write;
    logic                       hi_touch;
    logic                       we_e;
    logic                       we_o;
    logic [ROW_W-1:0]           wa_e;
    logic [ROW_W-1:0]           wa_o;
    logic [VW-1:0]              wd_e;
    logic [VW-1:0]              wd_o;

    assign w_eff = pbfa_pkg::eff_width(r_width_cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg <= pbfa_pkg::WIDTH_RST;
            r_count_cfg <= pbfa_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbfa_pkg::CFG_WIDTH: r_width_cfg <= i_cfg_data[pbfa_pkg::WID_W-1:0];
                pbfa_pkg::CFG_COUNT: r_count_cfg <= i_cfg_data;
                default: r_width_cfg <= r_width_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_idx <= i_element_index;
            r_val <= i_write_value;
        end
        if (i_cmd.calc) begin
            r_first  <= pbfa_pkg::FIRST_W'(r_idx) * pbfa_pkg::FIRST_W'(w_eff);
            r_wid    <= w_eff;
            r_mask   <= pbfa_pkg::width_mask(w_eff);
            r_cnt_ok <= ({1'b0, r_idx} < r_count_cfg);
        end
        if (i_cmd.check) begin
            r_st <= n_st;
        end
    end

    // address split and checks
    assign word_k  = r_first[pbfa_pkg::FIRST_W-1:6];
    assign word_kz = {1'b0, word_k};
    assign word_k1 = word_kz + (WADR_W+1)'(1);
    assign row_e   = word_k1[ROW_W:1];
    assign row_o   = word_kz[ROW_W:1];
    assign odd_lo  = word_k[0];
    assign bit_off = r_first[5:0];
    assign end_bit = {1'b0, r_first} + (pbfa_pkg::FIRST_W+1)'(r_wid);
    assign cap_bad = CMP_W'(end_bit) > CMP_W'(CAP_BITS);

    always_comb begin
        if (!r_cnt_ok || cap_bad) begin
            n_st = pbfa_pkg::ST_INDEX;
        end else if (r_op == pbfa_pkg::OP_WRITE && (r_val & ~r_mask) != '0) begin
            n_st = pbfa_pkg::ST_VALUE;
        end else begin
            n_st = pbfa_pkg::ST_OK;
        end
    end

    // extract and merge across the two words
    assign lo_word    = odd_lo ? r_q_o : r_q_e;
    assign hi_word    = odd_lo ? r_q_e : r_q_o;
    assign span       = {hi_word, lo_word};
    assign span_shift = span >> bit_off;
    assign rd_value   = span_shift[VW-1:0] & r_mask;
    assign wmask      = {{VW{1'b0}}, r_mask} << bit_off;
    assign wdata      = {{VW{1'b0}}, r_val} << bit_off;
    assign span_new   = (span & ~wmask) | (wdata & wmask);
    assign hi_touch   = wmask[2*VW-1:VW] != '0;
    assign do_write   = i_cmd.commit && r_st == pbfa_pkg::ST_OK && r_op == pbfa_pkg::OP_WRITE;

    always_comb begin
        if (i_cmd.clear_step) begin
            we_e = 1'b1;
            we_o = 1'b1;
            wa_e = r_clr_row;
            wa_o = r_clr_row;
            wd_e = '0;
            wd_o = '0;
        end else begin
            we_e = do_write && (!odd_lo || hi_touch);
            we_o = do_write && (odd_lo || hi_touch);
            wa_e = row_e;
            wa_o = row_o;
            wd_e = odd_lo ? span_new[2*VW-1:VW] : span_new[VW-1:0];
            wd_o = odd_lo ? span_new[VW-1:0] : span_new[2*VW-1:VW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_e) begin
            mem_e[wa_e] <= wd_e;
        end
        r_q_e <= mem_e[row_e];
    end

    always_ff @(posedge i_clk) begin
        if (we_o) begin
            mem_o[wa_o] <= wd_o;
        end
        r_q_o <= mem_o[row_o];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_m_status <= r_st;
            r_m_value  <= (r_st == pbfa_pkg::ST_OK && r_op == pbfa_pkg::OP_READ) ? rd_value : '0;
        end
    end

    assign o_sts.clear_last = (r_clr_row == ROW_W'(BANK_D - 1));
    assign o_sts.out_free   = !r_m_valid || i_m_ready;
    assign o_m_valid        = r_m_valid;
    assign o_read_value     = r_m_value;
    assign o_status         = r_m_status;

    `PBFA_ASSERT_NOW(a_refused_zero, r_m_valid && r_m_status != pbfa_pkg::ST_OK, r_m_value == '0, "refused item returned non-zero value")
    `PBFA_ASSERT_NOW(a_status_code, r_m_valid, r_m_status == pbfa_pkg::ST_OK || r_m_status == pbfa_pkg::ST_INDEX || r_m_status == pbfa_pkg::ST_VALUE, "undefined status code")
    `PBFA_ASSERT_NOW(a_clear_no_commit, i_cmd.clear_step, !i_cmd.commit && !i_cmd.capture, "item handled during clearing pass")

endmodule

[hw/rtl/packed_bit_field_array_unit.sv]
// Top level of the packed bit-field array unit: controller plus datapath.
// Depends on pbfa_pkg, pbfa_ctrl and pbfa_dp.
//
// Elements of 1..64 bits (width register 0 acts as 1, above 64 as 64) are packed
// LSB first in a store of STORE_BYTES bytes, kept as two banks of 64-bit words so
// that the two words any element touches are read in the same cycle. Each item goes
// through accept, index multiply, checks with the word reads, then the read-modify-write
// and result load, and a new item is accepted only after it; a stalled result holds the
// item in its last step. After reset a clearing pass zeroes one row of both banks per
// cycle, and no item is taken during it; configuration writes are taken at any time but
// must only be issued while idle.
module packed_bit_field_array_unit #(
    parameter int STORE_BYTES = pbfa_pkg::STORE_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pbfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // element_index [14:0], write_value [78:15], zero [79]
    input  logic [pbfa_pkg::S_DATA_W-1:0]       s_axis_tdata,
    // opcode [0]
    input  logic [pbfa_pkg::OPC_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_value [63:0]
    output logic [pbfa_pkg::M_DATA_W-1:0]       m_axis_tdata,
    // status [1:0]
    output logic [pbfa_pkg::ST_W-1:0]           m_axis_tuser
);

    pbfa_pkg::t_cmd cmd;
    pbfa_pkg::t_sts sts;

    pbfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pbfa_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (s_axis_tuser),
        .i_element_index (s_axis_tdata[pbfa_pkg::IDX_W-1:0]),
        .i_write_value   (s_axis_tdata[pbfa_pkg::IDX_W+pbfa_pkg::VAL_W-1:pbfa_pkg::IDX_W]),
        .o_m_valid       (m_axis_tvalid),
        .i_m_ready       (m_axis_tready),
        .o_read_value    (m_axis_tdata),
        .o_status        (m_axis_tuser)
    );

endmodule

[tb/sv/packed_bit_field_array_unit_tb.sv]
// Self-checking testbench for packed_bit_field_array_unit: streams read and write
// items under random sender gaps and receiver stalls, predicts each result in a scoreboard.
// Depends on pbfa_pkg and the unit's RTL.
module packed_bit_field_array_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbfa_pkg::*;

    localparam int STORE_BYTES = STORE_BYTES_DEF;
    localparam int STORE_BITS  = STORE_BYTES * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ST_W-1:0]  status;
    } t_access_result;

    class field_array_scoreboard;
        logic [7:0]       store_bytes [];
        logic [WID_W-1:0] width_reg;
        logic [CNT_W-1:0] count_reg;
        t_access_result   expected_results [$];
        int               mismatches;
        int               n_checked, n_reads, n_writes, n_bad_index, n_bad_value;

        function new(int nbytes);
            store_bytes = new[nbytes];
            foreach (store_bytes[i]) store_bytes[i] = 8'h00;
            width_reg = WIDTH_RST;
            count_reg = COUNT_RST;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_WIDTH) begin
                width_reg = data[WID_W-1:0];
            end else begin
                count_reg = data[CNT_W-1:0];
            end
        endfunction

        function int unsigned active_width();
            if (width_reg == 0) return 1;
            if (width_reg > 64) return 64;
            return 32'(width_reg);
        endfunction

        function void note_access(logic [OPC_W-1:0] op, logic [IDX_W-1:0] idx,
                                  logic [VAL_W-1:0] val);
            int unsigned     w;
            longint unsigned first, pos;
            t_access_result  res;
            w = active_width();
            first = 64'(idx) * 64'(w);
            res.value = '0;
            res.status = ST_OK;
            if ({1'b0, idx} >= count_reg || first + 64'(w) > 64'(STORE_BITS)) begin
                res.status = ST_INDEX;
                n_bad_index++;
            end else if (op == OP_READ) begin
                for (int i = 0; i < w; i++) begin
                    pos = first + 64'(i);
                    res.value[i] = store_bytes[pos / 8][pos % 8];
                end
                n_reads++;
            end else if (w < 64 && (val >> w) != 0) begin
                res.status = ST_VALUE;
                n_bad_value++;
            end else begin
                for (int i = 0; i < w; i++) begin
                    pos = first + 64'(i);
                    store_bytes[pos / 8][pos % 8] = val[i];
                end
                n_writes++;
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [VAL_W-1:0] value, logic [ST_W-1:0] status);
            t_access_result exp_res;
            n_checked++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: read_value %h status %0d", value, status);
                mismatches++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (value !== exp_res.value) begin
                $error("read_value expected %h got %h", exp_res.value, value);
                mismatches++;
            end
            if (status !== exp_res.status) begin
                $error("status expected %0d got %0d", exp_res.status, status);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [OPC_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [ST_W-1:0]       m_axis_tuser;

    field_array_scoreboard sb = new(STORE_BYTES);
    int                    cycle_count = 0;
    int                    burst_left = 0;
    int                    hot_base = 0;
    int                    settings_used = 0;
    int                    stall_left = 0;
    int                    stall_mode = 0;

    packed_bit_field_array_unit #(.STORE_BYTES(STORE_BYTES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL packed_bit_field_array_unit");
            $finish;
        end
    end

    // Receiver stall pattern: free running, random, alternating or mostly stalled.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 150);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ~m_axis_tready;
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_access(logic [OPC_W-1:0] op, logic [IDX_W-1:0] idx,
                               logic [VAL_W-1:0] val);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, idx};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_access(op, idx, val);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(logic [WID_W-1:0] width, logic [CNT_W-1:0] count);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= CFG_DATA_W'(width);
        @(posedge i_clk);
        sb.write_reg(CFG_WIDTH, CFG_DATA_W'(width));
        i_cfg_idx  <= CFG_COUNT;
        i_cfg_data <= count;
        @(posedge i_clk);
        sb.write_reg(CFG_COUNT, count);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned w, cap, cnt, lim, r;
        logic [IDX_W-1:0] idx;
        w   = sb.active_width();
        cap = STORE_BITS / w;
        cnt = 32'(sb.count_reg);
        lim = (cnt < cap) ? cnt : cap;
        r   = $urandom_range(0, 99);
        if (r < 10 || lim == 0) begin
            idx = IDX_W'($urandom_range(0, 32767));
        end else if (r < 25) begin
            case ($urandom_range(0, 3))
                0: idx = IDX_W'(lim - 1);
                1: idx = IDX_W'(lim);
                2: idx = IDX_W'(cap - 1);
                default: idx = IDX_W'(cnt);
            endcase
        end else if (r < 65) begin
            idx = IDX_W'(hot_base + $urandom_range(0, 15));
        end else begin
            idx = IDX_W'($urandom_range(0, lim - 1));
        end
        return idx;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned      w, r;
        logic [VAL_W-1:0] mask, full;
        w    = sb.active_width();
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        full = {$urandom, $urandom};
        r    = $urandom_range(0, 99);
        if (r < 12) return full;
        if (r < 20) return mask;
        if (r < 26) return (w < 64) ? (64'd1 << w) : full;
        return full & mask;
    endfunction

    function automatic void pick_hot_base();
        int unsigned w, cap, lim;
        w   = sb.active_width();
        cap = STORE_BITS / w;
        lim = (32'(sb.count_reg) < cap) ? 32'(sb.count_reg) : cap;
        hot_base = (lim > 16) ? $urandom_range(0, lim - 16) : 0;
    endfunction

    initial begin
        logic [WID_W-1:0] phase_width [PHASES];
        logic [CNT_W-1:0] phase_count [PHASES];
        logic [OPC_W-1:0] op;
        phase_width = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd37, 7'd13, 7'd63, 7'd3, 7'd59, 7'd8};
        phase_count = '{16'd65535, 16'd512, 16'd32768, 16'd100, 16'd885,
                        16'd0, 16'd600, 16'd20000, 16'd65535, 16'd4096};

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_READ;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset packing: eight-bit elements, count 4096.
        send_access(OP_WRITE, 15'd0, 64'hFF);
        send_access(OP_READ, 15'd0, '1);
        send_access(OP_WRITE, 15'd4095, 64'hA5);
        send_access(OP_READ, 15'd4095, '0);
        send_access(OP_READ, 15'd4096, '0);
        send_access(OP_WRITE, 15'd32767, '1);
        send_access(OP_WRITE, 15'd1, 64'h100);
        send_access(OP_READ, 15'd1, '0);
        send_access(OP_WRITE, 15'd1, 64'h0);
        wait_idle();

        // Full width: capacity ends before the count does.
        set_config(7'd64, 16'd65535);
        send_access(OP_READ, 15'd0, '0);
        send_access(OP_WRITE, 15'd511, '1);
        send_access(OP_READ, 15'd511, '0);
        send_access(OP_READ, 15'd512, '0);
        send_access(OP_WRITE, 15'd0, 64'h8000_0000_0000_0001);
        send_access(OP_READ, 15'd0, '0);
        wait_idle();

        // Width zero acts as one bit.
        set_config(7'd0, 16'd32768);
        send_access(OP_READ, 15'd0, '0);
        send_access(OP_WRITE, 15'd32767, 64'd1);
        send_access(OP_READ, 15'd32767, '0);
        send_access(OP_WRITE, 15'd5, 64'd2);
        wait_idle();

        // Oversized width with zero count refuses everything.
        set_config(7'd127, 16'd0);
        send_access(OP_READ, 15'd0, '0);
        send_access(OP_WRITE, 15'd0, '0);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_width[p], phase_count[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) pick_hot_base();
                op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
                send_access(op, pick_index(), pick_value());
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        $display("Run covered %0d items across %0d register settings, widths 0 to 127.",
                 sb.n_checked, settings_used);
        $display("Reads %0d, writes %0d, index refusals %0d, value refusals %0d.",
                 sb.n_reads, sb.n_writes, sb.n_bad_index, sb.n_bad_value);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS packed_bit_field_array_unit");
        end else begin
            $display("FAIL packed_bit_field_array_unit");
        end
        $finish;
    end

endmodule
